// ===== hw/rtl/stit_pkg.sv =====
// ----------------------------------------------------------------------------
// stit_pkg
// Types and codes shared by the sorted timestamp insert table.
// ----------------------------------------------------------------------------
package stit_pkg;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_LISTED    = 3'd1,
    ST_BAD_MONTH = 3'd2,
    ST_BAD_DAY   = 3'd3,
    ST_BAD_TIME  = 3'd4
  } status_t;

  localparam int KEY_W = 20;

  typedef struct packed {
    logic signed [7:0] month;
    logic signed [7:0] day;
    logic signed [7:0] hour;
    logic signed [7:0] minute;
    logic [15:0]       tag;
    logic              msg_empty;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [15:0] out_tag;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] tag;
    logic        empty;
  } entry_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   q;
    entry_t entry;
  } link_t;

  typedef struct packed {
    logic insert;
    logic dump;
  } cell_ctl_t;

  typedef struct packed {
    logic    is_end;
    logic    is_bad;
    status_t bad_status;
    entry_t  entry;
  } chk_t;

  function automatic logic [KEY_W-1:0] key_of(entry_t e);
    return {e.month, e.day, e.hour, e.minute};
  endfunction

endpackage

// ===== hw/rtl/stit_check.sv =====
// ----------------------------------------------------------------------------
// stit_check
// Classifies an incoming beat as end of input, bad field or valid entry.
// ----------------------------------------------------------------------------
module stit_check
  import stit_pkg::*;
(
  input  in_t  in_data,
  output chk_t chk
);

  logic bad_month;
  logic bad_day;
  logic bad_time;

  // hour*60+minute stays within 0..1440 with minute in 0..59 exactly when
  // hour is 0..23, or hour is 24 and minute is 0.
  always_comb begin
    bad_month = (in_data.month < 0) || (in_data.month > 8'sd12);
    bad_day   = (in_data.day < 0) || (in_data.day > 8'sd31);
    bad_time  = (in_data.minute < 0) || (in_data.minute > 8'sd59) ||
                (in_data.hour < 0) || (in_data.hour > 8'sd24) ||
                ((in_data.hour == 8'sd24) && (in_data.minute != 8'sd0));

    chk.is_end = (in_data.month == 8'sd0);
    chk.is_bad = !chk.is_end && (bad_month || bad_day || bad_time);
    if (bad_month) begin
      chk.bad_status = ST_BAD_MONTH;
    end else if (bad_day) begin
      chk.bad_status = ST_BAD_DAY;
    end else begin
      chk.bad_status = ST_BAD_TIME;
    end

    chk.entry.month  = in_data.month[3:0];
    chk.entry.day    = in_data.day[4:0];
    chk.entry.hour   = in_data.hour[4:0];
    chk.entry.minute = in_data.minute[5:0];
    chk.entry.tag    = in_data.tag;
    chk.entry.empty  = in_data.msg_empty;
  end

endmodule

// ===== hw/rtl/stit_cell.sv =====
// ----------------------------------------------------------------------------
// stit_cell
// One slot of the sorted table: compares against a new entry, shifts right
// on insertion and left on a dump.
// ----------------------------------------------------------------------------
module stit_cell
  import stit_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  link_t     prev,
  input  link_t     next,
  output link_t     self
);

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  logic   goes_before;

  // The table stays sorted with empty messages ahead of non-empty ones
  // among equal keys, so q is zero up to the insertion point and one after.
  always_comb begin
    goes_before = (key_of(entry_r) > key_of(new_entry)) ||
                  ((key_of(entry_r) == key_of(new_entry)) && !entry_r.empty);
    self.valid = valid_r;
    self.q     = valid_r ? goes_before : 1'b1;
    self.entry = entry_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ctl.insert) begin
      valid_nxt = valid_r | prev.valid;
      if (prev.q) begin
        entry_nxt = prev.entry;
      end else if (self.q) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.dump) begin
      valid_nxt = next.valid;
      entry_nxt = next.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hw/rtl/sorted_timestamp_insert_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_timestamp_insert_table_unit
// A status result is output in the cycle after its beat is accepted.
// Throughput: one beat per cycle outside dumps; the cells insert in parallel.
// A dump of n entries lists one per cycle from the head cell after the end or
// filling beat; busy stays high until the head cell empties. Reset clears all
// valid bits and the state; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_timestamp_insert_table_unit
  import stit_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t    state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_t      out_r, out_nxt;
  chk_t      chk;
  cell_ctl_t ctl;
  logic      accept;
  logic      table_full;

  link_t lnk [DEPTH+1];
  link_t nxt [DEPTH];

  stit_check u_check (
    .in_data (in_data),
    .chk     (chk)
  );

  // The stub ahead of the head cell counts as occupied and never moves.
  assign lnk[0] = '{valid: 1'b1, q: 1'b0, entry: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      assign nxt[i] = lnk[i+2];
    end else begin : g_tail
      assign nxt[i] = '0;
    end

    stit_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_entry (chk.entry),
      .prev      (lnk[i]),
      .next      (nxt[i]),
      .self      (lnk[i+1])
    );
  end

  assign busy       = (state_r == S_DUMP);
  assign accept     = start && !busy;
  // The tail cell fills on this insertion when its neighbor is occupied.
  assign table_full = lnk[DEPTH-1].valid;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    ctl           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (chk.is_end) begin
            if (lnk[1].valid) begin
              state_nxt = S_DUMP;
            end
          end else if (chk.is_bad) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = chk.bad_status;
            out_nxt.last   = 1'b1;
          end else begin
            ctl.insert     = 1'b1;
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_ACCEPTED;
            out_nxt.last   = !table_full;
            if (table_full) begin
              state_nxt = S_DUMP;
            end
          end
        end
      end
      S_DUMP: begin
        ctl.dump = 1'b1;
        if (lnk[1].valid) begin
          out_valid_nxt      = 1'b1;
          out_nxt.status     = ST_LISTED;
          out_nxt.out_month  = lnk[1].entry.month;
          out_nxt.out_day    = lnk[1].entry.day;
          out_nxt.out_hour   = lnk[1].entry.hour;
          out_nxt.out_minute = lnk[1].entry.minute;
          out_nxt.out_tag    = lnk[1].entry.tag;
          out_nxt.last       = !nxt[0].valid;
        end
        if (!nxt[0].valid) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/stit_checker.sv =====
// ----------------------------------------------------------------------------
// stit_checker
// Port-level checks on result ordering and formatting of the table.
// ----------------------------------------------------------------------------
module stit_checker
  import stit_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input in_t  in_data,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  logic bad_month_beat;

  assign bad_month_beat = start && !busy &&
                          ((in_data.month < 0) || (in_data.month > 8'sd12));

  // A status result ends its beat unless it triggers a dump.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_LISTED) && (out_data.status != ST_ACCEPTED)
    |-> out_data.last)
    else $error("error status without last");

  // Results that do not list an entry carry zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_LISTED)
    |-> (out_data.out_month == '0) && (out_data.out_day == '0) &&
        (out_data.out_hour == '0) && (out_data.out_minute == '0) &&
        (out_data.out_tag == '0))
    else $error("non-listing result with nonzero fields");

  a_bad_month: assert property (@(posedge clk) disable iff (!rst_n)
    bad_month_beat |=> out_valid && (out_data.status == ST_BAD_MONTH) && out_data.last)
    else $error("bad month not reported");

  // An unfinished dump continues in the very next cycle.
  a_dump_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_LISTED) && !out_data.last
    |=> out_valid && (out_data.status == ST_LISTED))
    else $error("dump interrupted");

  // An insertion that fills the table holds off new beats while it lists.
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_ACCEPTED) && !out_data.last
    |-> busy)
    else $error("table full without dump");

endmodule

bind sorted_timestamp_insert_table_unit stit_checker u_stit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_data   (in_data),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted timestamp insert table.
// Directed beats cover the field checks, equal-key ordering and dumps of an
// empty table. Random sessions of mostly valid reminders follow, each closed
// by an end beat, and some are long enough to fill the table. A behavioral
// copy of the table predicts every result beat, and the monitor checks each
// beat in order against that prediction.
// ----------------------------------------------------------------------------
module tb
  import stit_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH   = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  in_t    stamp_q[$];
  out_t   listing_q[$];
  entry_t sched_tbl[TBL_DEPTH];
  int     sched_cnt = 0;
  int     items_total = 0;
  int     beats_accepted = 0;
  int     mismatches = 0;
  int     cycle_cnt = 0;
  int     gap_left = 0;
  int     burst_left = 0;
  out_t   want;

  sorted_timestamp_insert_table_unit #(.DEPTH(TBL_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic in_t stamp(int m, int d, int h, int mi, int tag, int empty);
    in_t it;
    it.month     = m[7:0];
    it.day       = d[7:0];
    it.hour      = h[7:0];
    it.minute    = mi[7:0];
    it.tag       = tag[15:0];
    it.msg_empty = empty[0];
    return it;
  endfunction

  // Lists every stored entry in order, flags the final one, then empties the table.
  function automatic void list_table();
    out_t r;
    for (int i = 0; i < sched_cnt; i++) begin
      r            = '0;
      r.status     = ST_LISTED;
      r.out_month  = sched_tbl[i].month;
      r.out_day    = sched_tbl[i].day;
      r.out_hour   = sched_tbl[i].hour;
      r.out_minute = sched_tbl[i].minute;
      r.out_tag    = sched_tbl[i].tag;
      r.last       = (i == sched_cnt - 1);
      listing_q.push_back(r);
    end
    sched_cnt = 0;
  endfunction

  function automatic void file_reminder(in_t it);
    int m;
    int d;
    int h;
    int mi;
    int t;
    int pos;
    entry_t ne;
    logic [19:0] nk;
    logic [19:0] ek;
    out_t r;
    m  = $signed(it.month);
    d  = $signed(it.day);
    h  = $signed(it.hour);
    mi = $signed(it.minute);
    r  = '0;
    r.last = 1'b1;
    if (m == 0) begin
      list_table();
      return;
    end
    if (m < 0 || m > 12) begin
      r.status = ST_BAD_MONTH;
      listing_q.push_back(r);
      return;
    end
    if (d < 0 || d > 31) begin
      r.status = ST_BAD_DAY;
      listing_q.push_back(r);
      return;
    end
    t = h * 60 + mi;
    if (t < 0 || t > 24 * 60 || mi < 0 || mi > 59) begin
      r.status = ST_BAD_TIME;
      listing_q.push_back(r);
      return;
    end
    ne.month  = m[3:0];
    ne.day    = d[4:0];
    ne.hour   = h[4:0];
    ne.minute = mi[5:0];
    ne.tag    = it.tag;
    ne.empty  = it.msg_empty;
    nk  = {ne.month, ne.day, ne.hour, ne.minute};
    pos = sched_cnt;
    // An equal key goes ahead of the first stored entry that carries a message.
    for (int i = 0; i < sched_cnt; i++) begin
      ek = {sched_tbl[i].month, sched_tbl[i].day, sched_tbl[i].hour, sched_tbl[i].minute};
      if (ek > nk || (ek == nk && !sched_tbl[i].empty)) begin
        pos = i;
        break;
      end
    end
    for (int j = sched_cnt; j > pos; j--) sched_tbl[j] = sched_tbl[j-1];
    sched_tbl[pos] = ne;
    sched_cnt++;
    r.status = ST_ACCEPTED;
    if (sched_cnt >= TBL_DEPTH) begin
      r.last = 1'b0;
      listing_q.push_back(r);
      list_table();
    end else begin
      listing_q.push_back(r);
    end
  endfunction

  // Driver: a new beat is presented once the current one is taken and its gap has run out.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        file_reminder(in_data);
        beats_accepted++;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 11) == 0) begin
          burst_left = $urandom_range(10, 30);
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 11);
        end
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (stamp_q.size() > 0) begin
          start <= 1'b1;
          in_data <= stamp_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (listing_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, got st=%0d m=%0d d=%0d h=%0d mi=%0d tag=%h last=%0d",
                 $time, out_data.status, out_data.out_month, out_data.out_day,
                 out_data.out_hour, out_data.out_minute, out_data.out_tag, out_data.last);
      end else begin
        want = listing_q.pop_front();
        if (out_data.status !== want.status || out_data.out_month !== want.out_month ||
            out_data.out_day !== want.out_day || out_data.out_hour !== want.out_hour ||
            out_data.out_minute !== want.out_minute || out_data.out_tag !== want.out_tag ||
            out_data.last !== want.last) begin
          mismatches++;
          $display("%0t: mismatch, expected st=%0d m=%0d d=%0d h=%0d mi=%0d tag=%h last=%0d",
                   $time, want.status, want.out_month, want.out_day, want.out_hour,
                   want.out_minute, want.out_tag, want.last);
          $display("%0t:           actual st=%0d m=%0d d=%0d h=%0d mi=%0d tag=%h last=%0d",
                   $time, out_data.status, out_data.out_month, out_data.out_day,
                   out_data.out_hour, out_data.out_minute, out_data.out_tag, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int sess_len;
    int pm;
    int pd;
    int ph;
    int pmi;
    // Field checks, including which failure wins when several apply.
    stamp_q.push_back(stamp(0, 0, 0, 0, 16'h0000, 0));
    stamp_q.push_back(stamp(-9, 5, 5, 5, 16'h1234, 0));
    stamp_q.push_back(stamp(13, 40, 99, 99, 16'hFFFF, 1));
    stamp_q.push_back(stamp(99, 99, -9, -9, 16'hABCD, 0));
    stamp_q.push_back(stamp(12, -1, 0, 99, 16'h0001, 1));
    stamp_q.push_back(stamp(12, 32, 0, 0, 16'h8000, 0));
    stamp_q.push_back(stamp(1, 99, 0, 0, 16'h7FFF, 1));
    stamp_q.push_back(stamp(6, 15, 0, 60, 16'h0F0F, 0));
    stamp_q.push_back(stamp(6, 15, 0, -1, 16'hF0F0, 1));
    stamp_q.push_back(stamp(6, 15, 24, 1, 16'h5A5A, 0));
    stamp_q.push_back(stamp(6, 15, -1, 59, 16'hA5A5, 1));
    stamp_q.push_back(stamp(6, 15, 25, 0, 16'h3C3C, 0));
    stamp_q.push_back(stamp(6, 15, 24, 0, 16'hC3C3, 0));
    stamp_q.push_back(stamp(1, 0, 0, 0, 16'hFFFF, 0));
    stamp_q.push_back(stamp(12, 31, 23, 59, 16'h0000, 1));
    // Equal keys: order depends on whether the stored message is empty.
    stamp_q.push_back(stamp(7, 7, 7, 7, 16'h1111, 1));
    stamp_q.push_back(stamp(7, 7, 7, 7, 16'h2222, 0));
    stamp_q.push_back(stamp(7, 7, 7, 7, 16'h3333, 1));
    stamp_q.push_back(stamp(7, 7, 7, 7, 16'h4444, 0));
    stamp_q.push_back(stamp(7, 7, 7, 6, 16'h5555, 1));
    stamp_q.push_back(stamp(0, 0, 0, 0, 16'h0000, 0));
    stamp_q.push_back(stamp(0, 0, 0, 0, 16'hFFFF, 1));

    // Sessions of mostly valid reminders closed by an end beat; long ones fill the table.
    pm = 1; pd = 1; ph = 0; pmi = 0;
    sess_len = 34;
    while (stamp_q.size() < 255) begin
      for (int k = 0; k < sess_len; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          stamp_q.push_back(stamp(int'($urandom_range(0, 108)) - 9,
                                  int'($urandom_range(0, 108)) - 9,
                                  int'($urandom_range(0, 108)) - 9,
                                  int'($urandom_range(0, 108)) - 9,
                                  $urandom_range(0, 65535), $urandom_range(0, 1)));
        end else begin
          if ($urandom_range(0, 3) != 0) begin
            pm  = $urandom_range(1, 12);
            pd  = $urandom_range(0, 31);
            ph  = $urandom_range(0, 23);
            pmi = $urandom_range(0, 59);
            if ($urandom_range(0, 15) == 0) begin
              ph  = 24;
              pmi = 0;
            end
          end
          stamp_q.push_back(stamp(pm, pd, ph, pmi, $urandom_range(0, 65535),
                                  $urandom_range(0, 1)));
        end
      end
      stamp_q.push_back(stamp(0, $urandom_range(0, 31), $urandom_range(0, 23),
                              $urandom_range(0, 59), $urandom_range(0, 65535),
                              $urandom_range(0, 1)));
      sess_len = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
    end
    items_total = stamp_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (beats_accepted != items_total || listing_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && listing_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
